// ===== src/ffps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow field particle step: shared package
// Fixed-point constants, the Horner divisor table, the configuration register
// map and the link record that passes between the Horner cells.
// ----------------------------------------------------------------------------
package ffps_pkg;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int POS_W   = 18;
  localparam int CELL_W  = 10;
  localparam int PHASE_W = 16;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  // Q30 unity and pi/2, Q32 turn fraction of 1/(2 pi).
  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;

  // 0.09 and 0.13 radians per cell as Q0.32 turn fractions.
  localparam logic [25:0] KX_Q32 = 26'd61520875;
  localparam logic [26:0] KY_Q32 = 27'd88863486;

  // Step sizes 0.9 and 0.45 in Q16.
  localparam logic [15:0] STEP_X_Q16 = 16'd58982;
  localparam logic [15:0] STEP_Y_Q16 = 16'd29491;

  localparam logic [POS_W-1:0] POS_MAX = 18'h3FFFF;

  localparam int HORNER_CELLS = 4;

  // Divisors of the nested sine series, innermost term first.
  function automatic int horner_div(input int k);
    int d;
    d = 6;
    case (k)
      0:       d = 72;
      1:       d = 42;
      2:       d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1
  } cfg_reg_t;

  // Data handed from one Horner cell to the next.
  typedef struct packed {
    logic        vld;
    logic [30:0] w;
    logic [31:0] w2;
    logic [30:0] t;
  } sine_link_t;

endpackage

// ===== src/flow_field_particle_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow field particle step
// Moves one particle along the angle sin(0.09x + phase_a) + cos(0.13y -
// phase_b) and wraps it on the canvas border.
// ----------------------------------------------------------------------------
// The block takes one particle transaction in every cycle while in_stall is
// low and returns one result transaction for each, in order. The pipeline is
// the two rows of sine units in series (17 stages each, built from four
// Horner cells of three stages) plus the phase, angle conversion, step
// scaling and wrap stages. Each result leaves through an output register
// backed by one skid entry, so the pipeline keeps moving while the output
// stalls until a result reaches the end, and then stalls itself and the
// input until the skid entry drains. The canvas size registers are read by
// the wrap stage and should be written only when no transaction is in flight.
// ----------------------------------------------------------------------------
module flow_field_particle_step #(
  parameter int FRAC_BITS  = ffps_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ffps_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ffps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ffps_pkg::POS_W-1:0]     pos_x,
  input  logic [ffps_pkg::POS_W-1:0]     pos_y,
  input  logic [ffps_pkg::PHASE_W-1:0]   phase_a,
  input  logic [ffps_pkg::PHASE_W-1:0]   phase_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffps_pkg::POS_W-1:0]     new_x,
  output logic [ffps_pkg::POS_W-1:0]     new_y,
  output logic [ffps_pkg::CELL_W-1:0]    plot_col,
  output logic [ffps_pkg::CELL_W-1:0]    plot_row
);
  import ffps_pkg::*;

  // Signed width that holds a moved position and both wrap bounds.
  localparam int WW = (FRAC_BITS + 12 > 21) ? FRAC_BITS + 12 : 21;
  localparam int SH = 46 - FRAC_BITS;
  localparam int RSW = FRAC_BITS + 2;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [62:0] RND_A = 63'(1) << (61 - ANGLE_BITS);
  localparam logic [47:0] RND_S = 48'(1) << (SH - 1);

  // Configuration registers.
  logic [CFG_W-1:0] canvas_width, canvas_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 10'd80;
      canvas_height <= 10'd24;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together while the skid entry is free.
  logic en;
  logic skid_vld;

  assign en       = !skid_vld;
  assign in_stall = skid_vld;

  // Stage p1: position products for the phase terms.
  logic             v1;
  logic [44:0]      p1_prodx, p1_prody;
  logic [POS_W-1:0] p1_px, p1_py;
  logic [PHASE_W-1:0] p1_pa, p1_pb;

  // Stage p2: turn angles for sin(.) and cos(.) (cosine as a quarter turn on).
  logic             v2;
  logic [ANGLE_BITS-1:0] p2_ang_a, p2_ang_b;
  logic [POS_W-1:0] p2_px, p2_py;
  logic [31:0]      ta, tb;

  assign ta = 32'(p1_prodx >> FRAC_BITS) + {p1_pa, 16'h0000};
  assign tb = 32'(p1_prody >> FRAC_BITS) - {p1_pb, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_prodx <= 45'(pos_x) * 45'(KX_Q32);
      p1_prody <= 45'(pos_y) * 45'(KY_Q32);
      p1_px    <= pos_x;
      p1_py    <= pos_y;
      p1_pa    <= phase_a;
      p1_pb    <= phase_b;
      p2_ang_a <= ta[31 -: ANGLE_BITS];
      p2_ang_b <= tb[31 -: ANGLE_BITS] + QTR;
      p2_px    <= p1_px;
      p2_py    <= p1_py;
    end
  end

  // First row of sine units: the field angle terms.
  logic               sa_vld, cb_vld;
  logic signed [31:0] sa, cb;
  logic [POS_W-1:0]   sa_px, cb_py;

  ffps_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(POS_W)) u_sin_a (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (v2), .angle (p2_ang_a), .in_tag (p2_px),
    .out_vld (sa_vld), .sine (sa), .out_tag (sa_px)
  );

  ffps_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(POS_W)) u_cos_b (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (v2), .angle (p2_ang_b), .in_tag (p2_py),
    .out_vld (cb_vld), .sine (cb), .out_tag (cb_py)
  );

  // Stages r1 to r5: field angle in radians back to a turn fraction, rounded
  // to nearest and negated for a negative angle.
  logic               r1_v, r2_v, r3_v, r4_v, r5_v;
  logic signed [32:0] r1_sum;
  logic               r2_neg, r3_neg, r4_neg;
  logic [31:0]        r2_mag;
  logic [61:0]        r3_prod;
  logic [ANGLE_BITS-1:0] r4_t, r5_ang_s, r5_ang_c, ang_s;
  logic [POS_W-1:0]   r1_px, r1_py, r2_px, r2_py, r3_px, r3_py;
  logic [POS_W-1:0]   r4_px, r4_py, r5_px, r5_py;
  logic [62:0]        r4_rsum;

  assign r4_rsum = 63'(r3_prod) + RND_A;
  assign ang_s   = r4_neg ? ANGLE_BITS'(-r4_t) : r4_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
      r3_v <= 1'b0;
      r4_v <= 1'b0;
      r5_v <= 1'b0;
    end else if (en) begin
      r1_v <= sa_vld & cb_vld;
      r2_v <= r1_v;
      r3_v <= r2_v;
      r4_v <= r3_v;
      r5_v <= r4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sum   <= 33'(sa) + 33'(cb);
      r1_px    <= sa_px;
      r1_py    <= cb_py;
      r2_neg   <= r1_sum[32];
      r2_mag   <= r1_sum[32] ? 32'(-r1_sum) : 32'(r1_sum);
      r2_px    <= r1_px;
      r2_py    <= r1_py;
      r3_prod  <= 62'(r2_mag) * 62'(INV_2PI_Q32);
      r3_neg   <= r2_neg;
      r3_px    <= r2_px;
      r3_py    <= r2_py;
      r4_t     <= r4_rsum[61 -: ANGLE_BITS];
      r4_neg   <= r3_neg;
      r4_px    <= r3_px;
      r4_py    <= r3_py;
      r5_ang_s <= ang_s;
      r5_ang_c <= ang_s + QTR;
      r5_px    <= r4_px;
      r5_py    <= r4_py;
    end
  end

  // Second row of sine units: the step direction.
  logic               cx_vld, sy_vld;
  logic signed [31:0] cx, sy;
  logic [POS_W-1:0]   cx_px, sy_py;

  ffps_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(POS_W)) u_cos_step (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (r5_v), .angle (r5_ang_c), .in_tag (r5_px),
    .out_vld (cx_vld), .sine (cx), .out_tag (cx_px)
  );

  ffps_sine #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(POS_W)) u_sin_step (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (r5_v), .angle (r5_ang_s), .in_tag (r5_py),
    .out_vld (sy_vld), .sine (sy), .out_tag (sy_py)
  );

  // Stages s1 to s4: scale the direction to a step, rounding half away from
  // zero, and add it to the old position.
  logic             s1_v, s2_v, s3_v, s4_v, w1_v;
  logic             s1_nx, s1_ny, s2_nx, s2_ny, s3_nx, s3_ny;
  logic [30:0]      s1_mx, s1_my;
  logic [46:0]      s2_px_prod, s2_py_prod;
  logic [RSW-1:0]   s3_rx, s3_ry;
  logic [POS_W-1:0] s1_px, s1_py, s2_px, s2_py, s3_px, s3_py;
  logic signed [WW-1:0] s4_x, s4_y, w1_x, w1_y;
  logic [47:0]      rsum_x, rsum_y;
  logic signed [WW-1:0] step_x, step_y;

  assign rsum_x = 48'(s2_px_prod) + RND_S;
  assign rsum_y = 48'(s2_py_prod) + RND_S;
  assign step_x = s3_nx ? -signed'(WW'(s3_rx)) : signed'(WW'(s3_rx));
  assign step_y = s3_ny ? -signed'(WW'(s3_ry)) : signed'(WW'(s3_ry));

  // Wrap bounds, in the same fixed-point format as the positions. A canvas
  // narrower than two cells gives a negative upper bound, which is kept.
  logic signed [WW-1:0] lo_x, hi_x, lo_y, hi_y;

  assign lo_x = signed'(WW'(1) << FRAC_BITS);
  assign lo_y = signed'(WW'(3) << FRAC_BITS);
  assign hi_x = signed'((WW'(canvas_width) - WW'(2)) << FRAC_BITS);
  assign hi_y = signed'((WW'(canvas_height) - WW'(2)) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      w1_v <= 1'b0;
    end else if (en) begin
      s1_v <= cx_vld & sy_vld;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      w1_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_nx      <= cx[31];
      s1_ny      <= sy[31];
      s1_mx      <= cx[31] ? 31'(-cx) : 31'(cx);
      s1_my      <= sy[31] ? 31'(-sy) : 31'(sy);
      s1_px      <= cx_px;
      s1_py      <= sy_py;
      s2_px_prod <= 47'(s1_mx) * 47'(STEP_X_Q16);
      s2_py_prod <= 47'(s1_my) * 47'(STEP_Y_Q16);
      s2_nx      <= s1_nx;
      s2_ny      <= s1_ny;
      s2_px      <= s1_px;
      s2_py      <= s1_py;
      s3_rx      <= rsum_x[47:SH];
      s3_ry      <= rsum_y[47:SH];
      s3_nx      <= s2_nx;
      s3_ny      <= s2_ny;
      s3_px      <= s2_px;
      s3_py      <= s2_py;
      s4_x       <= signed'(WW'(s3_px)) + step_x;
      s4_y       <= signed'(WW'(s3_py)) + step_y;
      // First wrap test: below the low bound goes to the high bound.
      w1_x       <= (s4_x < lo_x) ? hi_x : s4_x;
      w1_y       <= (s4_y < lo_y) ? hi_y : s4_y;
    end
  end

  // Second wrap test, then saturation to the position range.
  logic signed [WW-1:0] w2_x, w2_y, fin_x, fin_y;

  always_comb begin
    w2_x  = (w1_x > hi_x) ? lo_x : w1_x;
    w2_y  = (w1_y > hi_y) ? lo_y : w1_y;
    fin_x = w2_x;
    fin_y = w2_y;
    if (w2_x < 0) begin
      fin_x = '0;
    end else if (w2_x > signed'(WW'(POS_MAX))) begin
      fin_x = signed'(WW'(POS_MAX));
    end
    if (w2_y < 0) begin
      fin_y = '0;
    end else if (w2_y > signed'(WW'(POS_MAX))) begin
      fin_y = signed'(WW'(POS_MAX));
    end
  end

  // Output register and skid entry. The skid entry catches the transaction
  // that leaves the pipeline while the output register is full and stalled.
  logic [POS_W-1:0]  sk_x, sk_y;
  logic [CELL_W-1:0] sk_col, sk_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (!out_stall) begin
        new_x    <= sk_x;
        new_y    <= sk_y;
        plot_col <= sk_col;
        plot_row <= sk_row;
        skid_vld <= 1'b0;
      end
    end else if (w1_v) begin
      if (!out_valid || !out_stall) begin
        new_x     <= POS_W'(fin_x);
        new_y     <= POS_W'(fin_y);
        plot_col  <= fin_x[FRAC_BITS +: CELL_W];
        plot_row  <= fin_y[FRAC_BITS +: CELL_W];
        out_valid <= 1'b1;
      end else begin
        sk_x     <= POS_W'(fin_x);
        sk_y     <= POS_W'(fin_y);
        sk_col   <= fin_x[FRAC_BITS +: CELL_W];
        sk_row   <= fin_y[FRAC_BITS +: CELL_W];
        skid_vld <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Checks on the output buffering and the wrap range.
  logic x_in_range, y_in_range, x_bounds_sane, y_bounds_sane;

  assign x_in_range = (signed'(WW'(new_x)) >= lo_x) && (signed'(WW'(new_x)) <= hi_x);
  assign y_in_range = (signed'(WW'(new_y)) >= lo_y) && (signed'(WW'(new_y)) <= hi_y);
  assign x_bounds_sane = (canvas_width >= 10'd8) && (hi_x <= signed'(WW'(POS_MAX)));
  assign y_bounds_sane = (canvas_height >= 10'd8) && (hi_y <= signed'(WW'(POS_MAX)));

  a_skid_has_output: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid entry holds a transaction while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_valid && out_stall))
    else $error("skid entry filled without a stalled output");

  a_x_wrapped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && x_bounds_sane) |-> x_in_range)
    else $error("column left the canvas wrap range");

  a_y_wrapped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && y_bounds_sane) |-> y_in_range)
    else $error("row left the canvas wrap range");

endmodule

// ===== src/ffps_horner_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner cell
// One term of the nested sine series: t_out = 1 - floor(floor(w2 * t) / D),
// over three stages (product, reciprocal estimate, correction).
// ----------------------------------------------------------------------------
module ffps_horner_cell #(
  parameter int DIVISOR = 6,
  parameter int TAG_W   = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ffps_pkg::sine_link_t in_link,
  input  logic [TAG_W-1:0]    in_tag,
  output ffps_pkg::sine_link_t out_link,
  output logic [TAG_W-1:0]    out_tag
);
  import ffps_pkg::*;

  // The reciprocal fits 32 bits and its estimate is at most one below the
  // true quotient for any 32-bit dividend.
  localparam int          SHIFT = 31 + $clog2(DIVISOR);
  localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / DIVISOR);
  localparam logic [31:0] DIV_C = 32'(DIVISOR);

  logic             a_vld, b_vld, c_vld;
  logic [30:0]      a_w, b_w, c_w;
  logic [31:0]      a_w2, b_w2, c_w2;
  logic [31:0]      a_p, b_p, b_q0;
  logic [30:0]      c_t;
  logic [TAG_W-1:0] a_tag, b_tag, c_tag;

  logic [62:0] prod_a;
  logic [63:0] prod_b;
  logic [31:0] rem, q;

  assign prod_a = 63'(in_link.w2) * 63'(in_link.t);
  assign prod_b = 64'(a_p) * 64'(RECIP);
  assign rem    = b_p - b_q0 * DIV_C;
  assign q      = b_q0 + 32'(rem >= DIV_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_link.vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_w   <= in_link.w;
      a_w2  <= in_link.w2;
      a_p   <= prod_a[61:30];
      a_tag <= in_tag;
      b_w   <= a_w;
      b_w2  <= a_w2;
      b_p   <= a_p;
      b_q0  <= 32'(prod_b >> SHIFT);
      b_tag <= a_tag;
      c_w   <= b_w;
      c_w2  <= b_w2;
      c_t   <= Q30_ONE - 31'(q);
      c_tag <= b_tag;
    end
  end

  assign out_link = '{vld: c_vld, w: c_w, w2: c_w2, t: c_t};
  assign out_tag  = c_tag;

endmodule

// ===== src/ffps_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine of a turn fraction
// Quadrant folding, scaling to Q30 radians, a row of Horner cells and a final
// product with clamp and sign. Seventeen stages, one angle per enabled cycle.
// ----------------------------------------------------------------------------
module ffps_sine #(
  parameter int ANGLE_BITS = ffps_pkg::ANGLE_BITS_DEF,
  parameter int TAG_W      = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [ANGLE_BITS-1:0] angle,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_vld,
  output logic signed [31:0]    sine,
  output logic [TAG_W-1:0]      out_tag
);
  import ffps_pkg::*;

  localparam int RW = ANGLE_BITS - 1;
  localparam int LW = TAG_W + 1;
  localparam logic [RW-1:0] QUARTER = RW'(1) << (ANGLE_BITS - 2);

  logic [1:0]    quad;
  logic [RW-1:0] r_low, r_fold;

  logic          v1, v2, v3, fv;
  logic [RW-1:0] s1_r;
  logic [30:0]   s2_w, s3_w;
  logic [31:0]   s3_w2, f_s;
  logic [LW-1:0] tag1, tag2, tag3, f_tag;

  logic [RW+30:0] prod2;
  logic [61:0]    prod3, prod4;
  logic [30:0]    mag;

  sine_link_t    link [HORNER_CELLS+1];
  logic [LW-1:0] tags [HORNER_CELLS+1];

  assign quad   = angle[ANGLE_BITS-1 -: 2];
  assign r_low  = RW'(angle[ANGLE_BITS-3:0]);
  assign r_fold = quad[0] ? QUARTER - r_low : r_low;

  assign prod2 = (RW+31)'(s1_r) * (RW+31)'(HALF_PI_Q30);
  assign prod3 = 62'(s2_w) * 62'(s2_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      fv      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      fv      <= link[HORNER_CELLS].vld;
      out_vld <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= r_fold;
      tag1  <= {quad[1], in_tag};
      s2_w  <= prod2[ANGLE_BITS+28:ANGLE_BITS-2];
      tag2  <= tag1;
      s3_w  <= s2_w;
      s3_w2 <= prod3[61:30];
      tag3  <= tag2;
    end
  end

  assign link[0] = '{vld: v3, w: s3_w, w2: s3_w2, t: Q30_ONE};
  assign tags[0] = tag3;

  for (genvar k = 0; k < HORNER_CELLS; k++) begin : g_cell
    ffps_horner_cell #(
      .DIVISOR (horner_div(k)),
      .TAG_W   (LW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_link  (link[k]),
      .in_tag   (tags[k]),
      .out_link (link[k+1]),
      .out_tag  (tags[k+1])
    );
  end

  assign prod4 = 62'(link[HORNER_CELLS].w) * 62'(link[HORNER_CELLS].t);
  assign mag   = (f_s > 32'(Q30_ONE)) ? Q30_ONE : f_s[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      f_s     <= prod4[61:30];
      f_tag   <= tags[HORNER_CELLS];
      sine    <= f_tag[TAG_W] ? -signed'(32'(mag)) : signed'(32'(mag));
      out_tag <= f_tag[TAG_W-1:0];
    end
  end

endmodule

// ===== sim/flow_field_particle_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow field particle step: self-checking testbench
// Drives particle transactions through the block with random idling on both
// channels, predicts every result with an independent fixed-point model of
// the field angle, step and border wrap, and checks each result in order.
// ----------------------------------------------------------------------------
module flow_field_particle_step_tb;
  import ffps_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;
  localparam longint unsigned ANG_MASK = (64'd1 << AB) - 1;
  localparam longint unsigned QTR = 64'd1 << (AB - 2);
  // Register indexes that the block has no register for.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  // Cycles the pipeline may still be busy once the last result has left.
  localparam int DRAIN_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [POS_W-1:0]  nx;
    logic [POS_W-1:0]  ny;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
  } moved_particle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CANVAS_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POS_W-1:0] pos_x = '0;
  logic [POS_W-1:0] pos_y = '0;
  logic [PHASE_W-1:0] phase_a = '0;
  logic [PHASE_W-1:0] phase_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [POS_W-1:0] new_x;
  logic [POS_W-1:0] new_y;
  logic [CELL_W-1:0] plot_col;
  logic [CELL_W-1:0] plot_row;

  // The testbench's own copy of the canvas size registers.
  longint canvas_w = 80;
  longint canvas_h = 24;

  moved_particle_t pending_moves[$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  bit out_idling = 1'b1;
  int out_burst = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  flow_field_particle_step u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .phase_a(phase_a), .phase_b(phase_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_x(new_x), .new_y(new_y), .plot_col(plot_col), .plot_row(plot_row)
  );

  // ------------------------------------------------------------------------
  // Prediction. Sine is a Taylor series in nested Horner form on a folded
  // quarter turn, every product floored back to Q30.
  // ------------------------------------------------------------------------
  function automatic longint unsigned sine_quadrant(input longint unsigned w);
    longint unsigned one, w2, t, s;
    one = 64'(Q30_ONE);
    w2 = (w * w) >> 30;
    t = one - w2 / 72;
    t = one - ((w2 * t) >> 30) / 42;
    t = one - ((w2 * t) >> 30) / 20;
    t = one - ((w2 * t) >> 30) / 6;
    s = (w * t) >> 30;
    return (s > one) ? one : s;
  endfunction

  function automatic longint sine_of_turn(input longint unsigned a);
    longint unsigned quad, r, w, m;
    a = a & ANG_MASK;
    quad = (a >> (AB - 2)) & 3;
    r = a & (QTR - 1);
    if (quad[0]) begin
      r = QTR - r;
    end
    w = (r * 64'(HALF_PI_Q30)) >> (AB - 2);
    m = sine_quadrant(w);
    return (quad >= 2) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned field_to_turn(input longint a);
    longint unsigned mag, t;
    mag = (a < 0) ? longint'(-a) : a;
    t = (mag * 64'(INV_2PI_Q32) + (64'd1 << (61 - AB))) >> (62 - AB);
    return (a < 0) ? ((64'd0 - t) & ANG_MASK) : (t & ANG_MASK);
  endfunction

  // Step size in FRAC_BITS, rounded half away from zero.
  function automatic longint step_size(input longint v, input longint unsigned k);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag * k + (64'd1 << (45 - FB))) >> (46 - FB);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Low edge first, then high edge, then saturation to the position range.
  function automatic longint wrap_border(input longint p, input longint lo_cells,
                                         input longint size);
    longint lo, hi;
    lo = lo_cells <<< FB;
    hi = (size - 2) <<< FB;
    if (p < lo) begin
      p = hi;
    end
    if (p > hi) begin
      p = lo;
    end
    if (p < 0) begin
      p = 0;
    end
    if (p > 64'(POS_MAX)) begin
      p = 64'(POS_MAX);
    end
    return p;
  endfunction

  function automatic moved_particle_t advect_particle(
      input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
      input logic [PHASE_W-1:0] pa, input logic [PHASE_W-1:0] pb);
    longint unsigned ta, tb, ang;
    longint field, nx, ny;
    moved_particle_t m;
    ta = ((64'(px) * 64'(KX_Q32)) >> FB) + (64'(pa) << 16);
    tb = ((64'(py) * 64'(KY_Q32)) >> FB) - (64'(pb) << 16);
    field = sine_of_turn((ta & 64'hFFFF_FFFF) >> (32 - AB))
          + sine_of_turn(((tb & 64'hFFFF_FFFF) >> (32 - AB)) + QTR);
    ang = field_to_turn(field);
    nx = longint'(px) + step_size(sine_of_turn(ang + QTR), 64'(STEP_X_Q16));
    ny = longint'(py) + step_size(sine_of_turn(ang), 64'(STEP_Y_Q16));
    nx = wrap_border(nx, 1, canvas_w);
    ny = wrap_border(ny, 3, canvas_h);
    m.nx = nx[POS_W-1:0];
    m.ny = ny[POS_W-1:0];
    m.col = nx[FB +: CELL_W];
    m.row = ny[FB +: CELL_W];
    return m;
  endfunction

  // ------------------------------------------------------------------------
  // Result checking, the output stall generator and the watchdog. All three
  // read the values from before the edge, as the block does.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    moved_particle_t exp_m;
    if (!rst && out_valid && !out_stall) begin
      checked_count <= checked_count + 1;
      if (pending_moves.size() == 0) begin
        $error("Result transaction with no particle outstanding");
        error_count++;
      end else begin
        exp_m = pending_moves.pop_front();
        if (new_x !== exp_m.nx) begin
          $error("new_x: expected %0d, actual %0d", exp_m.nx, new_x);
          error_count++;
        end
        if (new_y !== exp_m.ny) begin
          $error("new_y: expected %0d, actual %0d", exp_m.ny, new_y);
          error_count++;
        end
        if (plot_col !== exp_m.col) begin
          $error("plot_col: expected %0d, actual %0d", exp_m.col, plot_col);
          error_count++;
        end
        if (plot_row !== exp_m.row) begin
          $error("plot_row: expected %0d, actual %0d", exp_m.row, plot_row);
          error_count++;
        end
      end
    end
  end

  // The receiver holds off in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (!out_idling) begin
      out_burst <= 0;
      out_stall <= 1'b0;
    end else if (out_burst > 0) begin
      out_burst <= out_burst - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_burst <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Shared stimulus tasks. Every wait ends on a rising edge, so the driving
  // process always resumes at an edge.
  // ------------------------------------------------------------------------

  // Offers one particle after an optional gap and returns once it has been
  // taken. Valid is left high so back-to-back transactions need no toggle.
  task automatic send_particle(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                               input logic [PHASE_W-1:0] pa,
                               input logic [PHASE_W-1:0] pb, input int gap);
    moved_particle_t m;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    m = advect_particle(px, py, pa, pb);
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    phase_a <= pa;
    phase_b <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_moves.push_back(m);
    sent_count++;
  endtask

  // Lowers valid and waits until every result is back and the pipeline empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The enable is lowered after the edge that makes the write, and the task
  // waits for the next edge, so back-to-back writes see it low in between.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_CANVAS_WIDTH) begin
      canvas_w = value;
    end else if (idx == REG_CANVAS_HEIGHT) begin
      canvas_h = value;
    end
    @(posedge clk);
  endtask

  task automatic set_canvas(input int w, input int h);
    drain_pipeline();
    write_register(REG_CANVAS_WIDTH, CFG_W'(w));
    write_register(REG_CANVAS_HEIGHT, CFG_W'(h));
  endtask

  // A particle placed mostly on the current canvas, sometimes anywhere.
  task automatic send_random_particle(input int gap);
    logic [POS_W-1:0] px, py;
    if ($urandom_range(0, 9) < 7) begin
      px = POS_W'($urandom_range(0, 32'((canvas_w < 1 ? 1 : canvas_w) * 256 - 1)));
      py = POS_W'($urandom_range(0, 32'((canvas_h < 1 ? 1 : canvas_h) * 256 - 1)));
    end else begin
      px = POS_W'($urandom);
      py = POS_W'($urandom);
    end
    send_particle(px, py, PHASE_W'($urandom), PHASE_W'($urandom), gap);
  endtask

  function automatic int pick_gap(input bit idling);
    if (idling && $urandom_range(0, 5) == 0) begin
      return $urandom_range(1, 19);
    end
    return 0;
  endfunction

  // ------------------------------------------------------------------------
  // Tests.
  // ------------------------------------------------------------------------

  // Field extremes and the phase quarter points on the reset canvas.
  task automatic test_field_extremes();
    send_particle('0, '0, '0, '0, 0);
    send_particle(POS_MAX, POS_MAX, '1, '1, 0);
    send_particle(18'd10240, 18'd3072, 16'd16384, 16'd0, 0);
    send_particle(18'd10240, 18'd3072, 16'd32768, 16'd49152, 1);
    send_particle(18'h2AAAA, 18'h15555, 16'hAAAA, 16'h5555, 0);
    send_particle(18'h15555, 18'h2AAAA, 16'h5555, 16'hAAAA, 0);
  endtask

  // Positions on and just past each border of the canvas, low edge first.
  task automatic test_border_wrap();
    send_particle(18'd0, 18'd768, 16'd0, 16'd0, 0);
    send_particle(18'd255, 18'd767, 16'd100, 16'd200, 0);
    send_particle(18'd256, 18'd768, 16'd16384, 16'd0, 0);
    send_particle(18'(78 * 256), 18'(22 * 256), 16'd0, 16'd32768, 0);
    send_particle(18'(78 * 256 + 1), 18'(22 * 256 + 1), 16'd49152, 16'd0, 2);
    send_particle(18'(79 * 256), 18'(23 * 256), 16'd8000, 16'd9000, 0);
  endtask

  // Both registers at their extremes, a tiny canvas whose high bound lies
  // below zero, and writes to unused indexes, which must change nothing.
  task automatic test_register_map();
    set_canvas(1023, 1023);
    send_particle(18'd200, 18'd700, 16'd0, 16'd0, 0);
    send_particle(POS_MAX, POS_MAX, 16'd20000, 16'd40000, 0);
    send_particle(18'(1021 * 256 + 5), 18'(1021 * 256 + 5), 16'd0, 16'd0, 0);
    set_canvas(8, 8);
    send_particle(18'd300, 18'd800, 16'd1, 16'd2, 0);
    send_particle(18'd1536, 18'd1536, 16'd3000, 16'd3000, 0);
    set_canvas(0, 1);
    send_particle(18'd1000, 18'd1000, 16'd0, 16'd0, 0);
    send_particle(18'd0, 18'd0, 16'd65535, 16'd0, 0);
    drain_pipeline();
    write_register(REG_SPARE_2, 10'h3FF);
    write_register(REG_SPARE_3, 10'h155);
    send_particle(18'd512, 18'd512, 16'd1234, 16'd4321, 0);
    set_canvas(2, 3);
    send_particle(18'd512, 18'd1000, 16'd1234, 16'd4321, 0);
  endtask

  // Random particles on the reset canvas, then random sizes, idling in some
  // stretches only, and all results drain at each size change and once more.
  task automatic test_random_particles();
    bit idling;
    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      if (phase_no == 0) begin
        set_canvas(80, 24);
      end else begin
        set_canvas($urandom_range(8, 1023), $urandom_range(8, 1023));
      end
      for (int i = 0; i < 50; i++) begin
        if (i % 25 == 0) begin
          idling = $urandom_range(0, 3) != 0;
          out_idling = idling;
        end
        send_random_particle(pick_gap(idling));
        if (phase_no == 3 && i == 20) begin
          drain_pipeline();
        end
      end
    end
  endtask

  // Full rate with neither side idling.
  task automatic test_full_rate();
    set_canvas(80, 24);
    out_idling = 1'b0;
    for (int i = 0; i < 100; i++) begin
      send_random_particle(0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_border_wrap();
    test_register_map();
    test_random_particles();
    test_full_rate();
    drain_pipeline();
    $display("Sent %0d particle transactions and checked %0d results over",
             sent_count, checked_count);
    $display("reset, extreme, tiny and random canvas sizes, with and without idling.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== flow_field_particle_step.f =====
src/ffps_pkg.sv
src/ffps_horner_cell.sv
src/ffps_sine.sv
src/flow_field_particle_step.sv
sim/flow_field_particle_step_tb.sv
